>>> rtl/nearest_point_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Nearest point search assertion macros
// Shared property forms for the nearest point search unit.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_POINT_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while reset is asserted.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while reset is asserted.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// Nearest point search package
// Widths, item codes, stream and state types shared by the search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

	localparam int MAX_POINTS  = 256;
	localparam int COORD_WIDTH = 16;
	localparam int AXES        = 3;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int SQ_W        = 2 * COORD_WIDTH;
	localparam int SUM_W       = SQ_W + 2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [AXES-1:0] point_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic [SUM_W-1:0] sum;
		point_t           pt;
	} stream_t;

	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] idx;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMPTY
	} state_t;

endpackage

`default_nettype wire

>>> rtl/nps_point_store.sv
// ----------------------------------------------------------------------------
// Nearest point search point store
// One write port and one registered read port over the stored points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nps_point_store
	import nps_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire point_t           wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output point_t                rdata
);

	point_t mem [MAX_POINTS];
	point_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/nps_axis_cell.sv
// ----------------------------------------------------------------------------
// Nearest point search axis cell
// Holds one query coordinate and adds the squared difference on its axis to
// the running distance of each point item that passes through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nps_axis_cell
	import nps_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_load,
	input  wire coord_t  q_coord,
	input  wire stream_t in_s,
	output stream_t      out_s
);

	coord_t                    q_q;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [2*DIFF_W-1:0] prod;
	logic [SQ_W-1:0]           sq;
	stream_t                   nxt;
	logic                      valid_q;
	stream_t                   data_q;

	always_comb begin
		diff = $signed({in_s.pt[0][COORD_WIDTH-1], in_s.pt[0]})
			- $signed({q_q[COORD_WIDTH-1], q_q});
		prod = diff * diff;
		sq   = prod[SQ_W-1:0];
		nxt  = in_s;
		nxt.sum = in_s.sum + {{(SUM_W-SQ_W){1'b0}}, sq};
		nxt.pt[AXES-2:0] = in_s.pt[AXES-1:1];
	end

	always_ff @(posedge clk) begin
		if (q_load) begin
			q_q <= q_coord;
		end
		data_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_s.valid;
		end
	end

	always_comb begin
		out_s       = data_q;
		out_s.valid = valid_q;
	end

endmodule

`default_nettype wire

>>> rtl/nps_min_tracker.sv
// ----------------------------------------------------------------------------
// Nearest point search minimum tracker
// Keeps the smallest distance seen in a scan and reports its index at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nps_min_tracker
	import nps_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire stream_t in_s,
	output result_t      res
);

	logic [SUM_W-1:0] best_sum_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             done_q;
	logic             take;

	// The first entry of a scan always wins; later ones only when strictly closer.
	assign take = in_s.valid && ((in_s.idx == '0) || (in_s.sum < best_sum_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_sum_q <= in_s.sum;
			best_idx_q <= in_s.idx;
		end
		if (in_s.valid && in_s.last) begin
			res_idx_q <= take ? in_s.idx : best_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_s.valid && in_s.last;
		end
	end

	assign res.done = done_q;
	assign res.idx  = res_idx_q;

endmodule

`default_nettype wire

>>> rtl/nearest_point_search_unit.sv
// ----------------------------------------------------------------------------
// Nearest point search unit
// Stores up to 256 points and returns the index of the stored point nearest
// to a query point, lowest index first on equal distance.
// ----------------------------------------------------------------------------
// A load item leaves busy low. A query item with N points in use (N capped at
// 256) keeps busy high through its scan and drain: the single read port of the
// point store delivers one point per cycle into a row of three axis cells and
// a minimum tracker, and the result strobe comes at the end.
// With no points in use the result, index 0, comes in the cycle right after
// the query is taken and busy is high for that one cycle. The result is shown
// on nearest_index for one cycle with done high and is not held, so the
// receiver must take it in that cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_point_search_unit_assert.svh"

module nearest_point_search_unit
	import nps_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             action,
	input  wire logic [IDX_W-1:0] entry_index,
	input  wire coord_t           coord_x,
	input  wire coord_t           coord_y,
	input  wire coord_t           coord_z,
	output logic                  done,
	output logic [IDX_W-1:0]      nearest_index,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] points_in_use_q;
	logic [CNT_W-1:0] scan_len;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             load_acc;
	logic             query_acc;
	logic             last_issue;
	logic             rd_en;
	logic             empty_done;
	point_t           wr_point;
	point_t           rd_point;
	logic             meta_valid_s1;
	logic             meta_last_s1;
	logic [IDX_W-1:0] meta_idx_s1;
	stream_t          chain [AXES+1];
	coord_t           q_coords [AXES];
	result_t          trk_res;

	assign accept    = start && !busy;
	assign load_acc  = accept && (action == ACT_LOAD);
	assign query_acc = accept && (action == ACT_QUERY);

	assign scan_len   = (points_in_use_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
		: points_in_use_q;
	assign last_issue = (cnt_q == (scan_len - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= '0;
		end else if (cfg_we) begin
			points_in_use_q <= cfg_wdata;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					state_nxt = (scan_len == '0) ? ST_EMPTY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (trk_res.done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		rd_en      = 1'b0;
		empty_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
				busy = 1'b1;
			end
			ST_EMPTY: begin
				empty_done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			meta_valid_s1 <= 1'b0;
		end else begin
			state_q       <= state_nxt;
			meta_valid_s1 <= rd_en;
			if (query_acc) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_last_s1 <= last_issue;
		meta_idx_s1  <= cnt_q[IDX_W-1:0];
	end

	assign wr_point[0] = coord_x;
	assign wr_point[1] = coord_y;
	assign wr_point[2] = coord_z;

	nps_point_store u_store (
		.clk   (clk),
		.we    (load_acc),
		.waddr (entry_index),
		.wdata (wr_point),
		.re    (rd_en),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rd_point)
	);

	always_comb begin
		chain[0].valid = meta_valid_s1;
		chain[0].last  = meta_last_s1;
		chain[0].idx   = meta_idx_s1;
		chain[0].sum   = '0;
		chain[0].pt    = rd_point;
	end

	assign q_coords[0] = coord_x;
	assign q_coords[1] = coord_y;
	assign q_coords[2] = coord_z;

	for (genvar g = 0; g < AXES; g++) begin : g_cell
		nps_axis_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.q_load  (query_acc),
			.q_coord (q_coords[g]),
			.in_s    (chain[g]),
			.out_s   (chain[g+1])
		);
	end

	nps_min_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s   (chain[AXES]),
		.res    (trk_res)
	);

	assign done          = trk_res.done || empty_done;
	assign nearest_index = empty_done ? '0 : trk_res.idx;

	`NPS_ASSERT_NOW(a_done_while_busy, done, busy,
		"Result item issued while the unit was idle.")
	`NPS_ASSERT_NEXT(a_empty_query, query_acc && (scan_len == '0),
		done && (nearest_index == '0),
		"Query with no points in use did not return index zero.")
	`NPS_ASSERT_NEXT(a_load_no_busy, load_acc, !busy && !done,
		"Load item left the unit busy or produced a result.")
	`NPS_ASSERT_NOW(a_stream_in_query, chain[AXES].valid,
		(state_q == ST_SCAN) || (state_q == ST_DRAIN),
		"Point item reached the tracker outside a query scan.")

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Nearest point search unit testbench
// Loads points into the store and issues nearest-point queries through the
// start/busy command port, with random sender gaps and register changes
// between phases. A scoreboard predicts untyped query results from its own
// store copy, queues them with typed ones, and checks each done strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import nps_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int ITEM_TARGET    = 850;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 270;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;

	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_QUERY,
		ROW_COUNT
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		int               arg;
		coord_t           x;
		coord_t           y;
		coord_t           z;
		bit               typed;
		logic [IDX_W-1:0] want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             action = ACT_LOAD;
	logic [IDX_W-1:0] entry_index = '0;
	coord_t           coord_x = '0;
	coord_t           coord_y = '0;
	coord_t           coord_z = '0;
	logic             done;
	logic [IDX_W-1:0] nearest_index;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	coord_t           pts_x [MAX_POINTS];
	coord_t           pts_y [MAX_POINTS];
	coord_t           pts_z [MAX_POINTS];
	int               scan_count = 0;
	logic [IDX_W-1:0] pending_nearest [$];
	logic [IDX_W-1:0] due_index;
	row_t             script [$];
	row_t             cur_row;
	int               fail_cnt = 0;
	int               items_sent = 0;
	int               idle_cycles = 0;
	int               phase_no = 0;
	int               phase_count;
	bit               burst = 1'b0;

	nearest_point_search_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.entry_index   (entry_index),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.coord_z       (coord_z),
		.done          (done),
		.nearest_index (nearest_index),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int scanned_entries();
		return (scan_count > MAX_POINTS) ? MAX_POINTS : scan_count;
	endfunction

	function automatic logic [IDX_W-1:0] closest_entry(coord_t qx, coord_t qy, coord_t qz);
		longint dx, dy, dz, dsq, best_dsq;
		int best;
		bit have;
		best = 0;
		best_dsq = 0;
		have = 1'b0;
		for (int i = 0; i < scanned_entries(); i++) begin
			dx = longint'(pts_x[i]) - longint'(qx);
			dy = longint'(pts_y[i]) - longint'(qy);
			dz = longint'(pts_z[i]) - longint'(qz);
			dsq = dx * dx + dy * dy + dz * dz;
			if (!have || dsq < best_dsq) begin
				have = 1'b1;
				best = i;
				best_dsq = dsq;
			end
		end
		return best[IDX_W-1:0];
	endfunction

	function automatic coord_t any_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(int'($urandom_range(0, 16)) - 8);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t near_coord(coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return coord_t'(v);
	endfunction

	function automatic row_t mk_row(row_kind_t kind, int arg, int x, int y, int z, bit typed,
			int want);
		row_t r;
		r.kind = kind;
		r.arg = arg;
		r.x = coord_t'(x);
		r.y = coord_t'(y);
		r.z = coord_t'(z);
		r.typed = typed;
		r.want = IDX_W'(want);
		return r;
	endfunction

	task automatic send_item(input logic act, input logic [IDX_W-1:0] idx, input coord_t x,
			input coord_t y, input coord_t z, input bit typed, input logic [IDX_W-1:0] want);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		entry_index <= idx;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (busy);
		items_sent++;
		if (act == ACT_LOAD) begin
			pts_x[idx] = x;
			pts_y[idx] = y;
			pts_z[idx] = z;
		end else begin
			pending_nearest.push_back(typed ? want : closest_entry(x, y, z));
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_nearest.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input int value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		scan_count = value;
	endtask

	task automatic random_item();
		int lim, src, pick;
		logic [IDX_W-1:0] idx;
		coord_t x, y, z;
		lim = scanned_entries();
		idx = IDX_W'($urandom);
		src = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, MAX_POINTS - 1);
		pick = $urandom_range(0, 11);
		x = any_coord();
		y = any_coord();
		z = any_coord();
		if ($urandom_range(0, 9) < 5) begin
			if (lim > 0 && $urandom_range(0, 1) == 1)
				idx = IDX_W'($urandom_range(0, lim - 1));
			if (pick < 3) begin
				x = pts_x[src];
				y = pts_y[src];
				z = pts_z[src];
			end else if (pick < 5) begin
				x = near_coord(pts_x[src]);
				y = near_coord(pts_y[src]);
				z = near_coord(pts_z[src]);
			end
			send_item(ACT_LOAD, idx, x, y, z, 1'b0, '0);
		end else begin
			if (pick < 4) begin
				x = near_coord(pts_x[src]);
				y = near_coord(pts_y[src]);
				z = near_coord(pts_z[src]);
			end else if (pick < 6) begin
				x = pts_x[src];
				y = pts_y[src];
				z = pts_z[src];
			end
			send_item(ACT_QUERY, idx, x, y, z, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_nearest.size() == 0) begin
				if (fail_cnt < REPORT_LIMIT)
					$display("unexpected result: nearest_index %0d with no query pending",
						nearest_index);
				fail_cnt++;
			end else begin
				due_index = pending_nearest.pop_front();
				if (nearest_index !== due_index) begin
					if (fail_cnt < REPORT_LIMIT)
						$display("nearest_index mismatch: expected %0d, got %0d",
							due_index, nearest_index);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		script.push_back(mk_row(ROW_QUERY, 0, 0, 0, 0, 1'b1, 0));
		script.push_back(mk_row(ROW_QUERY, 255, -32768, 32767, -1, 1'b1, 0));
		script.push_back(mk_row(ROW_LOAD, 0, -32768, -32768, -32768, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 1, 32767, 32767, 32767, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 2, 0, 0, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 3, 0, 0, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 4, -1, 1, -32768, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 255, 12345, -54, 7, 1'b0, 0));
		script.push_back(mk_row(ROW_COUNT, 5, 0, 0, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_QUERY, 170, -32768, -32768, -32768, 1'b1, 0));
		script.push_back(mk_row(ROW_QUERY, 85, 32767, 32767, 32767, 1'b1, 1));
		script.push_back(mk_row(ROW_QUERY, 0, 0, 0, 0, 1'b1, 2));
		script.push_back(mk_row(ROW_QUERY, 255, -1, 1, -32767, 1'b1, 4));
		script.push_back(mk_row(ROW_QUERY, 3, 32767, -32768, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_COUNT, 1, 0, 0, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_QUERY, 1, 32767, 32767, 32767, 1'b1, 0));
		script.push_back(mk_row(ROW_COUNT, 2, 0, 0, 0, 1'b0, 0));
		script.push_back(mk_row(ROW_LOAD, 1, -32768, -32768, -32768, 1'b0, 0));
		script.push_back(mk_row(ROW_QUERY, 0, -32768, -32768, -32768, 1'b1, 0));
		script.push_back(mk_row(ROW_QUERY, 0, -32767, -32768, -32768, 1'b1, 0));
		script.push_back(mk_row(ROW_LOAD, 0, 32767, 32767, 32767, 1'b0, 0));
		script.push_back(mk_row(ROW_QUERY, 0, -32768, -32768, -32768, 1'b1, 1));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[k]) begin
			cur_row = script[k];
			case (cur_row.kind)
				ROW_COUNT: begin
					write_count(cur_row.arg);
				end
				ROW_LOAD: begin
					send_item(ACT_LOAD, IDX_W'(cur_row.arg), cur_row.x, cur_row.y, cur_row.z,
						1'b0, '0);
				end
				default: begin
					send_item(ACT_QUERY, IDX_W'(cur_row.arg), cur_row.x, cur_row.y, cur_row.z,
						cur_row.typed, cur_row.want);
				end
			endcase
		end

		// Every entry is written before any query can scan past the directed points.
		settle();
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (i % 32 == 0)
				burst = ($urandom_range(0, 2) == 0);
			send_item(ACT_LOAD, IDX_W'(i), any_coord(), any_coord(), any_coord(), 1'b0, '0);
		end

		while (items_sent < ITEM_TARGET) begin
			phase_no++;
			case (phase_no)
				1: phase_count = MAX_POINTS;
				2: phase_count = 511;
				3: phase_count = 0;
				default: begin
					case ($urandom_range(0, 19))
						0: phase_count = 0;
						1: phase_count = MAX_POINTS;
						2: phase_count = 511;
						3: phase_count = $urandom_range(MAX_POINTS + 1, 510);
						4: phase_count = $urandom_range(100, MAX_POINTS - 1);
						default: phase_count = $urandom_range(1, 12);
					endcase
				end
			endcase
			write_count(phase_count);
			burst = ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(10, 40)) begin
				if ($urandom_range(0, 49) == 0)
					settle();
				random_item();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_nearest.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_point_store.sv
rtl/nps_axis_cell.sv
rtl/nps_min_tracker.sv
rtl/nearest_point_search_unit.sv
verif/tb.sv
